// ===== rtl/core/rou_pkg.sv =====
package rou_pkg;

    // Table sizes
    localparam int CAPACITY     = 256;
    localparam int MAX_POSITION = 1023;

    // Port widths of the item fields
    localparam int POSITION_W = 10;
    localparam int KEY_W      = 32;
    localparam int INDEX_W    = 9;
    localparam int VALUE_W    = 10;
    localparam int COUNT_W    = 9;
    localparam int ADDR_W     = 3;

    // Register indexes (byte address bits above the word offset)
    localparam logic REG_ORDER_BY_RANK = 1'b0;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_OLD2NEW = 2'd1,
        CMD_NEW2OLD = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_A_START,
        OP_A_READ,
        OP_A_LATCH,
        OP_A_COUNT,
        OP_A_WRITE,
        OP_B_START,
        OP_B_READ,
        OP_B_WRITE,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_ctl_cmd;

    typedef struct packed {
        logic clr_last;
        logic a_done;
        logic cnt_last;
        logic out_hold;
        logic last_in;
    } t_dp_stat;

endpackage

// ===== rtl/core/rank_order_renumbering_unit.sv =====
// Lookups: one item per cycle unless stalled; result registered, valid in the next cycle.
// Renumbering after a last load: a clear sweep of the old-to-new table, then a pass over
// the entries that fills the new-to-old table (a pairwise rank count per entry through
// the one read port in rank mode only), then a sweep that fills the old-to-new table.
// Synchronous active-low reset; afterwards a clearing pass over MAX_POSITION+1 entries
// zeroes the old-to-new table while input items are held off (config writes still taken).
module rank_order_renumbering_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_command,
    input  logic [rou_pkg::POSITION_W-1:0]      i_position,
    input  logic [rou_pkg::KEY_W-1:0]           i_rank_key,
    input  logic                                i_last_load,
    input  logic [rou_pkg::INDEX_W-1:0]         i_new_index,
    // result item channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [rou_pkg::VALUE_W-1:0]         o_mapped_value,
    output logic [rou_pkg::COUNT_W-1:0]         o_used_count,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rou_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    rou_pkg::t_ctl_cmd ctl_cmd;
    rou_pkg::t_dp_stat dp_stat;
    logic              r_order_by_rank;
    logic              cfg_sel;

    // Register index sits above the 32-bit word offset
    assign cfg_sel = paddr[rou_pkg::ADDR_W-1] == rou_pkg::REG_ORDER_BY_RANK;
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? {31'b0, r_order_by_rank} : '0;

    // Write the mode bit on the access phase; writes elsewhere are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_by_rank <= 1'b1;
        end else if (psel && penable && pwrite && cfg_sel) begin
            r_order_by_rank <= pwdata[0];
        end
    end

    // Sequencer: clear sweep, rank count per entry (rank mode only), then table build
    rou_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_order_by_rank (r_order_by_rank),
        .i_stat          (dp_stat),
        .o_cmd           (ctl_cmd),
        .o_stall         (o_stall)
    );

    // Entry buffer, mapping tables, counters and the output register
    rou_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctl_cmd),
        .o_stat          (dp_stat),
        .i_order_by_rank (r_order_by_rank),
        .i_command       (i_command),
        .i_position      (i_position),
        .i_rank_key      (i_rank_key),
        .i_last_load     (i_last_load),
        .i_new_index     (i_new_index),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_mapped_value  (o_mapped_value),
        .o_used_count    (o_used_count)
    );

endmodule

// ===== rtl/core/rou_ctrl.sv =====
module rou_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_order_by_rank,
    input  rou_pkg::t_dp_stat  i_stat,
    output rou_pkg::t_ctl_cmd  o_cmd,
    output logic               o_stall
);

    typedef enum logic [3:0] {
        S_RST_CLEAR,
        S_IDLE,
        S_CLEAR,
        S_A_START,
        S_A_READ,
        S_A_LATCH,
        S_A_COUNT,
        S_A_WRITE,
        S_B_START,
        S_B_READ,
        S_B_WRITE,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   idle_free;

    assign idle_free = (r_state == S_IDLE) && !i_stat.out_hold;
    assign o_stall   = !idle_free;

    always_comb begin
        o_cmd.accept = idle_free && i_valid;
        o_cmd.op     = rou_pkg::OP_IDLE;
        n_state      = r_state;
        unique case (r_state)
            S_RST_CLEAR: begin
                o_cmd.op = rou_pkg::OP_CLEAR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (o_cmd.accept && i_stat.last_in) n_state = S_CLEAR;
            end
            S_CLEAR: begin
                o_cmd.op = rou_pkg::OP_CLEAR;
                if (i_stat.clr_last) n_state = S_A_START;
            end
            S_A_START: begin
                o_cmd.op = rou_pkg::OP_A_START;
                n_state  = S_A_READ;
            end
            S_A_READ: begin
                if (i_stat.a_done) begin
                    n_state = S_B_START;
                end else begin
                    o_cmd.op = rou_pkg::OP_A_READ;
                    n_state  = S_A_LATCH;
                end
            end
            S_A_LATCH: begin
                o_cmd.op = rou_pkg::OP_A_LATCH;
                n_state  = i_order_by_rank ? S_A_COUNT : S_A_WRITE;
            end
            S_A_COUNT: begin
                o_cmd.op = rou_pkg::OP_A_COUNT;
                if (i_stat.cnt_last) n_state = S_A_WRITE;
            end
            S_A_WRITE: begin
                o_cmd.op = rou_pkg::OP_A_WRITE;
                n_state  = S_A_READ;
            end
            S_B_START: begin
                o_cmd.op = rou_pkg::OP_B_START;
                n_state  = S_B_READ;
            end
            S_B_READ: begin
                if (i_stat.a_done) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.op = rou_pkg::OP_B_READ;
                    n_state  = S_B_WRITE;
                end
            end
            S_B_WRITE: begin
                o_cmd.op = rou_pkg::OP_B_WRITE;
                n_state  = S_B_READ;
            end
            S_FINISH: begin
                o_cmd.op = rou_pkg::OP_FINISH;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/rou_dp.sv =====
module rou_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rou_pkg::t_ctl_cmd               i_cmd,
    output rou_pkg::t_dp_stat               o_stat,
    input  logic                            i_order_by_rank,
    input  logic [1:0]                      i_command,
    input  logic [rou_pkg::POSITION_W-1:0]  i_position,
    input  logic [rou_pkg::KEY_W-1:0]       i_rank_key,
    input  logic                            i_last_load,
    input  logic [rou_pkg::INDEX_W-1:0]     i_new_index,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [rou_pkg::VALUE_W-1:0]     o_mapped_value,
    output logic [rou_pkg::COUNT_W-1:0]     o_used_count
);

    localparam int CAPACITY     = rou_pkg::CAPACITY;
    localparam int MAX_POSITION = rou_pkg::MAX_POSITION;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int POS_W = $clog2(MAX_POSITION + 1);
    localparam int KEY_W = rou_pkg::KEY_W;
    localparam int VAL_W = rou_pkg::VALUE_W;
    localparam int USE_W = rou_pkg::COUNT_W;

    logic [POS_W-1:0] r_ent_pos [CAPACITY];
    logic [KEY_W-1:0] r_ent_key [CAPACITY];
    logic [CNT_W-1:0] r_o2n     [MAX_POSITION + 1];
    logic [POS_W-1:0] r_n2o     [CAPACITY];

    logic [CNT_W-1:0] r_loaded;
    logic [CNT_W-1:0] r_ren_cnt;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] r_j;
    logic [CNT_W-1:0] r_rank;
    logic [POS_W-1:0] r_clr_addr;
    logic [KEY_W-1:0] r_key_rd;
    logic [POS_W-1:0] r_pos_rd;
    logic [KEY_W-1:0] r_key_i;
    logic [POS_W-1:0] r_pos_i;
    logic [CNT_W-1:0] r_o2n_rd;
    logic [POS_W-1:0] r_n2o_rd;
    logic             r_out_valid;
    logic             r_out_zero;
    logic             r_out_n2o;

    rou_pkg::t_cmd    cmd;
    rou_pkg::t_op     op;
    logic             accept;
    logic             pos_in_range;
    logic             pos_ok_load;
    logic             nidx_ok;
    logic [POS_W-1:0] pos_addr;
    logic [IDX_W-1:0] nidx_addr;
    logic [IDX_W-1:0] ent_addr;
    logic [CNT_W-1:0] j_prev;
    logic             beats;
    logic             load_wr;
    logic             lookup;
    logic             clr_last;

    assign cmd          = rou_pkg::t_cmd'(i_command);
    assign op           = i_cmd.op;
    assign accept       = i_cmd.accept;
    assign pos_in_range = 32'(i_position) <= 32'(MAX_POSITION);
    assign pos_ok_load  = pos_in_range && (i_position != '0);
    assign pos_addr     = POS_W'(i_position);
    assign nidx_ok      = (i_new_index != '0) && (32'(i_new_index) <= 32'(r_ren_cnt));
    assign nidx_addr    = IDX_W'(32'(i_new_index) - 32'd1);
    assign load_wr      = accept && (cmd == rou_pkg::CMD_LOAD) && pos_ok_load
                          && (r_loaded < CNT_W'(CAPACITY));
    assign lookup       = accept && ((cmd == rou_pkg::CMD_OLD2NEW)
                          || (cmd == rou_pkg::CMD_NEW2OLD));
    assign j_prev       = r_j - CNT_W'(1);
    // Entry j beats entry i on a larger key, or an equal key loaded earlier
    assign beats        = (r_key_rd > r_key_i) || ((r_key_rd == r_key_i) && (j_prev < r_i));
    assign clr_last     = r_clr_addr == POS_W'(MAX_POSITION);

    always_comb begin
        case (op)
            rou_pkg::OP_A_READ:  ent_addr = r_i[IDX_W-1:0];
            rou_pkg::OP_A_LATCH: ent_addr = '0;
            default:             ent_addr = r_j[IDX_W-1:0];
        endcase
    end

    assign o_stat.clr_last = clr_last;
    assign o_stat.a_done   = r_i == r_loaded;
    assign o_stat.cnt_last = r_j == r_loaded;
    assign o_stat.out_hold = r_out_valid && i_stall;
    assign o_stat.last_in  = (cmd == rou_pkg::CMD_LOAD) && i_last_load;

    // Entry buffer
    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            r_ent_pos[r_loaded[IDX_W-1:0]] <= pos_addr;
            r_ent_key[r_loaded[IDX_W-1:0]] <= i_rank_key;
        end
        r_key_rd <= r_ent_key[ent_addr];
        r_pos_rd <= r_ent_pos[ent_addr];
    end

    // Old-to-new table
    always_ff @(posedge i_clk) begin
        if (op == rou_pkg::OP_CLEAR) begin
            r_o2n[r_clr_addr] <= '0;
        end else if (op == rou_pkg::OP_B_WRITE) begin
            r_o2n[r_n2o_rd] <= r_i + CNT_W'(1);
        end
        if (accept && (cmd == rou_pkg::CMD_OLD2NEW) && pos_in_range) begin
            r_o2n_rd <= r_o2n[pos_addr];
        end
    end

    // New-to-old table, 0-based
    always_ff @(posedge i_clk) begin
        if (op == rou_pkg::OP_A_WRITE) begin
            r_n2o[r_rank[IDX_W-1:0]] <= r_pos_i;
        end
        if (op == rou_pkg::OP_B_READ) begin
            r_n2o_rd <= r_n2o[r_i[IDX_W-1:0]];
        end else if (accept && (cmd == rou_pkg::CMD_NEW2OLD) && nidx_ok) begin
            r_n2o_rd <= r_n2o[nidx_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == rou_pkg::OP_A_LATCH) begin
            r_key_i <= r_key_rd;
            r_pos_i <= r_pos_rd;
        end
        if (lookup) begin
            r_out_n2o  <= cmd == rou_pkg::CMD_NEW2OLD;
            r_out_zero <= (cmd == rou_pkg::CMD_NEW2OLD) ? !nidx_ok : !pos_in_range;
        end else if (op == rou_pkg::OP_FINISH) begin
            r_out_zero <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= '0;
            r_ren_cnt   <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_rank      <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_wr) r_loaded <= r_loaded + CNT_W'(1);
            case (op)
                rou_pkg::OP_CLEAR:   r_clr_addr <= clr_last ? '0 : r_clr_addr + POS_W'(1);
                rou_pkg::OP_A_START: r_i <= '0;
                rou_pkg::OP_A_LATCH: begin
                    r_j    <= CNT_W'(1);
                    r_rank <= i_order_by_rank ? '0 : r_i;
                end
                rou_pkg::OP_A_COUNT: begin
                    r_j <= r_j + CNT_W'(1);
                    if (beats) r_rank <= r_rank + CNT_W'(1);
                end
                rou_pkg::OP_A_WRITE: r_i <= r_i + CNT_W'(1);
                rou_pkg::OP_B_START: r_i <= '0;
                rou_pkg::OP_B_WRITE: r_i <= r_i + CNT_W'(1);
                rou_pkg::OP_FINISH:  r_ren_cnt <= r_loaded;
                default: ;
            endcase
            if (lookup || (op == rou_pkg::OP_FINISH)) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_mapped_value = r_out_zero ? '0
                          : (r_out_n2o ? VAL_W'(r_n2o_rd) : VAL_W'(r_o2n_rd));
    assign o_used_count   = USE_W'(r_ren_cnt);

endmodule

// ===== rtl/core/rou_chk.sv =====
module rou_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic [1:0]                      i_command,
    input logic                            i_last_load,
    input logic [rou_pkg::INDEX_W-1:0]     i_new_index,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [rou_pkg::VALUE_W-1:0]     o_mapped_value,
    input logic [rou_pkg::COUNT_W-1:0]     o_used_count
);

    logic acc;
    assign acc = i_valid && !o_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_mapped_value) && $stable(o_used_count))
        else $error("stalled result changed");

    a_lookup_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_command == rou_pkg::CMD_OLD2NEW || i_command == rou_pkg::CMD_NEW2OLD)
        |=> o_valid)
        else $error("lookup gave no result");

    a_plain_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_command == rou_pkg::CMD_LOAD && !i_last_load && !(o_valid && i_stall)
        |=> !o_valid)
        else $error("plain load gave a result");

    a_last_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_command == rou_pkg::CMD_LOAD && i_last_load |=> o_stall)
        else $error("accepted item during renumbering");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_command == rou_pkg::CMD_NEW2OLD && i_new_index == '0
        |=> o_mapped_value == '0)
        else $error("new index 0 did not map to 0");

endmodule

bind rank_order_renumbering_unit rou_chk u_rou_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_command      (i_command),
    .i_last_load    (i_last_load),
    .i_new_index    (i_new_index),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_mapped_value (o_mapped_value),
    .o_used_count   (o_used_count)
);
